### sv/cbd_pkg.sv
`default_nettype none

package cbd_pkg;

	localparam int LEN_BITS = 24;
	localparam logic [LEN_BITS-1:0] MAX_LEN_RESET = '1;

	localparam logic [7:0] CHAR_CR = 8'h0D;
	localparam logic [7:0] CHAR_LF = 8'h0A;

	// Two bytes follow each chunk's data (and the final zero-length line).
	localparam logic [1:0] SKIP_COUNT = 2'd2;

	typedef enum logic [1:0] {
		KIND_DATA = 2'd0,
		KIND_END  = 2'd1,
		KIND_ERR  = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		PH_LEN     = 3'd0,
		PH_LF      = 3'd1,
		PH_DATA    = 3'd2,
		PH_SKIP    = 3'd3,
		PH_ENDSKIP = 3'd4,
		PH_DONE    = 3'd5
	} phase_t;

	typedef struct packed {
		logic       valid;
		logic [7:0] data;
		kind_t      kind;
	} result_t;

	typedef struct packed {
		phase_t phase;
	} status_t;

	function automatic logic is_hex(input logic [7:0] c);
		return (c >= "0" && c <= "9") || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
	endfunction

	function automatic logic [3:0] hex_val(input logic [7:0] c);
		logic [7:0] v;
		if (c >= "0" && c <= "9") begin
			v = c - 8'h30;
		end else if (c >= "a" && c <= "f") begin
			v = c - 8'h57;
		end else begin
			v = c - 8'h37;
		end
		return v[3:0];
	endfunction

endpackage

`default_nettype wire

### sv/cbd_parser.sv
`default_nettype none

module cbd_parser (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         step,
	input  wire logic [7:0]                   data_byte,
	input  wire logic                         new_message,
	input  wire logic [cbd_pkg::LEN_BITS-1:0] max_chunk_len,
	output cbd_pkg::result_t                  res,
	output cbd_pkg::status_t                  status
);

	localparam int NV_BITS = cbd_pkg::LEN_BITS + 4;

	cbd_pkg::phase_t               phase_q, phase_d;
	logic [cbd_pkg::LEN_BITS-1:0] remaining_q, remaining_d;
	logic                          digit_seen_q, digit_seen_d;
	logic                          in_ext_q, in_ext_d;
	logic [1:0]                    skip_left_q, skip_left_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= cbd_pkg::PH_LEN;
			remaining_q  <= '0;
			digit_seen_q <= 1'b0;
			in_ext_q     <= 1'b0;
			skip_left_q  <= '0;
		end else if (step) begin
			phase_q      <= phase_d;
			remaining_q  <= remaining_d;
			digit_seen_q <= digit_seen_d;
			in_ext_q     <= in_ext_d;
			skip_left_q  <= skip_left_d;
		end
	end

	always_comb begin
		cbd_pkg::phase_t               ph;
		logic [cbd_pkg::LEN_BITS-1:0] rem;
		logic [NV_BITS-1:0]           nv;
		logic [1:0]                   skl;

		// A new message restarts the parser before this byte is looked at.
		ph           = new_message ? cbd_pkg::PH_LEN : phase_q;
		rem          = new_message ? '0 : remaining_q;
		digit_seen_d = new_message ? 1'b0 : digit_seen_q;
		in_ext_d     = new_message ? 1'b0 : in_ext_q;
		skl          = new_message ? 2'd0 : skip_left_q;

		phase_d     = ph;
		remaining_d = rem;
		skip_left_d = skl;
		res         = '{valid: 1'b0, data: 8'd0, kind: cbd_pkg::KIND_DATA};
		nv          = {rem, 4'd0} | NV_BITS'(cbd_pkg::hex_val(data_byte));

		unique case (ph)
			cbd_pkg::PH_LEN: begin
				if (data_byte == cbd_pkg::CHAR_CR) begin
					if (!digit_seen_d) begin
						phase_d = cbd_pkg::PH_DONE;
						res     = '{valid: 1'b1, data: 8'd0, kind: cbd_pkg::KIND_ERR};
					end else begin
						phase_d = cbd_pkg::PH_LF;
					end
				end else if (!in_ext_d) begin
					if (!cbd_pkg::is_hex(data_byte)) begin
						in_ext_d = 1'b1;
					end else if (nv > NV_BITS'(max_chunk_len)) begin
						phase_d = cbd_pkg::PH_DONE;
						res     = '{valid: 1'b1, data: 8'd0, kind: cbd_pkg::KIND_ERR};
					end else begin
						remaining_d  = nv[cbd_pkg::LEN_BITS-1:0];
						digit_seen_d = 1'b1;
					end
				end
			end
			cbd_pkg::PH_LF: begin
				if (data_byte != cbd_pkg::CHAR_LF) begin
					phase_d = cbd_pkg::PH_DONE;
					res     = '{valid: 1'b1, data: 8'd0, kind: cbd_pkg::KIND_ERR};
				end else begin
					skip_left_d = cbd_pkg::SKIP_COUNT;
					phase_d     = (rem == '0) ? cbd_pkg::PH_ENDSKIP : cbd_pkg::PH_DATA;
				end
			end
			cbd_pkg::PH_DATA: begin
				if (rem != '0) begin
					remaining_d = rem - cbd_pkg::LEN_BITS'(1);
				end
				if (remaining_d == '0) begin
					phase_d     = cbd_pkg::PH_SKIP;
					skip_left_d = cbd_pkg::SKIP_COUNT;
				end
				res = '{valid: 1'b1, data: data_byte, kind: cbd_pkg::KIND_DATA};
			end
			cbd_pkg::PH_SKIP: begin
				if (skl != 2'd0) begin
					skip_left_d = skl - 2'd1;
				end
				if (skip_left_d == 2'd0) begin
					phase_d      = cbd_pkg::PH_LEN;
					remaining_d  = '0;
					digit_seen_d = 1'b0;
					in_ext_d     = 1'b0;
					skip_left_d  = 2'd0;
				end
			end
			cbd_pkg::PH_ENDSKIP: begin
				if (skl != 2'd0) begin
					skip_left_d = skl - 2'd1;
				end
				if (skip_left_d == 2'd0) begin
					phase_d = cbd_pkg::PH_DONE;
					res     = '{valid: 1'b1, data: 8'd0, kind: cbd_pkg::KIND_END};
				end
			end
			default: begin
				// Done and unused codes drop bytes until the next message.
			end
		endcase
	end

	assign status.phase = phase_q;

endmodule

`default_nettype wire

### sv/chunked_body_decoder_top.sv
// A byte in the input register passes through the parser to the result register (m_tvalid).
// Throughput: one byte per cycle while the result register is free or emptied; the parser
// state and any result update in the cycle the byte leaves the input register.
// Bytes that produce no result (length line, skip bytes, after end) give nothing.
// Reset (arst_n low, asynchronous) empties both registers, returns the parser
// to a length line and sets max_chunk_len to its largest value.
`default_nettype none

module chunked_body_decoder_top (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         s_tvalid,
	output logic                              s_tready,
	input  wire logic [7:0]                   s_tdata,  // [7:0] data_byte
	input  wire logic [0:0]                   s_tuser,  // [0] new_message
	output logic                              m_tvalid,
	input  wire logic                         m_tready,
	output logic [7:0]                        m_tdata,  // [7:0] out_byte
	output logic [1:0]                        m_tuser,  // [1:0] kind
	input  wire logic                         cfg_valid,
	output logic                              cfg_ready,
	input  wire logic [cbd_pkg::LEN_BITS-1:0] cfg_data
);

	logic                          valid_s1;
	logic [7:0]                    byte_s1;
	logic                          newmsg_s1;
	logic                          valid_s2;
	logic [7:0]                    byte_s2;
	cbd_pkg::kind_t                kind_s2;
	logic [cbd_pkg::LEN_BITS-1:0] max_len_q;
	logic                          advance;
	cbd_pkg::result_t              res;
	cbd_pkg::status_t              status;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= cbd_pkg::MAX_LEN_RESET;
		end else if (cfg_valid) begin
			max_len_q <= cfg_data;
		end
	end

	// A word moves on from the input register when the result register is
	// free or being emptied in the same cycle.
	assign advance  = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1   <= s_tdata;
			newmsg_s1 <= s_tuser[0];
		end
	end

	cbd_parser u_parser (
		.clk           (clk),
		.arst_n        (arst_n),
		.step          (advance),
		.data_byte     (byte_s1),
		.new_message   (newmsg_s1),
		.max_chunk_len (max_len_q),
		.res           (res),
		.status        (status)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance && res.valid) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res.valid) begin
			byte_s2 <= res.data;
			kind_s2 <= res.kind;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = byte_s2;
	assign m_tuser  = kind_s2;

	a_kind_legal: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tuser == cbd_pkg::KIND_DATA || m_tuser == cbd_pkg::KIND_END
			|| m_tuser == cbd_pkg::KIND_ERR))
		else $error("result kind out of range");

	a_nondata_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser != cbd_pkg::KIND_DATA) |-> (m_tdata == 8'd0))
		else $error("end or error word carries a nonzero byte");

	a_stop_after_end: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && res.valid && res.kind != cbd_pkg::KIND_DATA)
			|=> (status.phase == cbd_pkg::PH_DONE))
		else $error("parser did not stop after end or error");

	a_done_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && status.phase == cbd_pkg::PH_DONE && !newmsg_s1) |-> !res.valid)
		else $error("result produced after end of message");

endmodule

`default_nettype wire

### tb/sv/chunked_body_decoder_checker.sv
`default_nettype none

module chunked_body_decoder_checker
	import cbd_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                s_tvalid,
	input  wire logic                s_tready,
	input  wire logic [7:0]          s_tdata,  // [7:0] data_byte
	input  wire logic [0:0]          s_tuser,  // [0] new_message
	input  wire logic                m_tvalid,
	input  wire logic                m_tready,
	input  wire logic [7:0]          m_tdata,  // [7:0] out_byte
	input  wire logic [1:0]          m_tuser,  // [1:0] kind
	input  wire logic                cfg_valid,
	input  wire logic                cfg_ready,
	input  wire logic [LEN_BITS-1:0] cfg_data,
	output int                       fail_count,
	output int                       pending,
	output int                       data_seen,
	output int                       end_seen,
	output int                       err_seen
);

	typedef struct packed {
		logic [7:0] data;
		kind_t      kind;
	} decoded_t;

	decoded_t expected_q[$];

	// Our own copy of the parser state and the length limit.
	logic [LEN_BITS-1:0] max_len;
	logic [LEN_BITS-1:0] count;
	phase_t              ph;
	logic                got_digit;
	logic                in_ext;
	logic [1:0]          skips;

	initial begin
		fail_count = 0;
		pending = 0;
		data_seen = 0;
		end_seen = 0;
		err_seen = 0;
	end

	function automatic int hex_digit(input logic [7:0] c);
		if (c >= "0" && c <= "9") begin
			return int'(c) - 48;
		end
		if (c >= "a" && c <= "f") begin
			return int'(c) - 87;
		end
		if (c >= "A" && c <= "F") begin
			return int'(c) - 55;
		end
		return -1;
	endfunction

	task automatic restart_line();
		ph = PH_LEN;
		count = '0;
		got_digit = 1'b0;
		in_ext = 1'b0;
		skips = '0;
	endtask

	task automatic decode_byte(input logic [7:0] b, input logic restart, output logic hit,
			output decoded_t res);
		int          d;
		logic [31:0] nv;
		hit = 1'b0;
		res = '{data: 8'h00, kind: KIND_DATA};
		if (restart) begin
			restart_line();
		end
		case (ph)
			PH_LEN: begin
				if (b == CHAR_CR) begin
					if (!got_digit) begin
						ph = PH_DONE;
						hit = 1'b1;
						res.kind = KIND_ERR;
					end else begin
						ph = PH_LF;
					end
				end else if (!in_ext) begin
					d = hex_digit(b);
					if (d < 0) begin
						in_ext = 1'b1;
					end else begin
						nv = ({8'h00, count} << 4) | {28'h0, d[3:0]};
						if (nv > {8'h00, max_len} || nv > 32'h00FF_FFFF) begin
							ph = PH_DONE;
							hit = 1'b1;
							res.kind = KIND_ERR;
						end else begin
							count = nv[LEN_BITS-1:0];
							got_digit = 1'b1;
						end
					end
				end
			end
			PH_LF: begin
				if (b != CHAR_LF) begin
					ph = PH_DONE;
					hit = 1'b1;
					res.kind = KIND_ERR;
				end else begin
					skips = SKIP_COUNT;
					ph = (count == 0) ? PH_ENDSKIP : PH_DATA;
				end
			end
			PH_DATA: begin
				if (count > 0) begin
					count = count - 1'b1;
				end
				if (count == 0) begin
					ph = PH_SKIP;
					skips = SKIP_COUNT;
				end
				hit = 1'b1;
				res.data = b;
			end
			PH_SKIP: begin
				if (skips > 0) begin
					skips = skips - 1'b1;
				end
				if (skips == 0) begin
					restart_line();
				end
			end
			PH_ENDSKIP: begin
				if (skips > 0) begin
					skips = skips - 1'b1;
				end
				if (skips == 0) begin
					ph = PH_DONE;
					hit = 1'b1;
					res.kind = KIND_END;
				end
			end
			default: begin
			end
		endcase
	endtask

	task automatic flag_mismatch(input string what, input decoded_t exp, input decoded_t got);
		fail_count++;
		if (fail_count <= 10) begin
			$display("Mismatch, %s: expected data %02h kind %0d, got data %02h kind %0d",
				what, exp.data, exp.kind, got.data, got.kind);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		decoded_t exp;
		decoded_t got;
		logic     hit;
		if (!arst_n) begin
			max_len = MAX_LEN_RESET;
			restart_line();
			expected_q.delete();
		end else begin
			if (m_tvalid && m_tready) begin
				got = '{data: m_tdata, kind: kind_t'(m_tuser)};
				if (expected_q.size() == 0) begin
					flag_mismatch("word with nothing expected", got, got);
				end else begin
					exp = expected_q.pop_front();
					if (got !== exp) begin
						flag_mismatch("wrong word", exp, got);
					end
					case (exp.kind)
						KIND_DATA: data_seen++;
						KIND_END:  end_seen++;
						default:   err_seen++;
					endcase
				end
			end
			if (cfg_valid && cfg_ready) begin
				max_len = cfg_data;
			end
			if (s_tvalid && s_tready) begin
				decode_byte(s_tdata, s_tuser[0], hit, exp);
				if (hit) begin
					expected_q.push_back(exp);
				end
			end
		end
		pending = expected_q.size();
	end

endmodule

`default_nettype wire

### tb/sv/tb_chunked_body_decoder_top.sv
`default_nettype none

module tb_chunked_body_decoder_top;
	import cbd_pkg::*;

	typedef struct {
		logic [7:0] b;
		logic       nm;
	} raw_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                s_tvalid = 1'b0;
	logic [7:0]          s_tdata = 8'h00;
	logic [0:0]          s_tuser = 1'b0;
	logic                m_tready = 1'b0;
	logic                cfg_valid = 1'b0;
	logic [LEN_BITS-1:0] cfg_data = '0;
	wire logic           s_tready;
	wire logic           m_tvalid;
	wire logic [7:0]     m_tdata;
	wire logic [1:0]     m_tuser;
	wire logic           cfg_ready;

	int fail_count;
	int pending;
	int data_seen;
	int end_seen;
	int err_seen;

	raw_t                raw_q[$];
	logic [LEN_BITS-1:0] limit = MAX_LEN_RESET;
	logic                restart = 1'b0;
	bit                  no_idle = 1'b0;
	int                  sent = 0;
	int                  messages = 0;
	int                  settings = 0;

	chunked_body_decoder_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	chunked_body_decoder_checker u_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data),
		.fail_count (fail_count),
		.pending    (pending),
		.data_seen  (data_seen),
		.end_seen   (end_seen),
		.err_seen   (err_seen)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(negedge clk) begin
		m_tready <= no_idle || ($urandom_range(0, 99) >= 21);
	end

	initial begin
		#3000000;
		$display("Timeout: the decoder stopped moving words");
		$display("*** FAILED ***");
		$finish;
	end

	// The first byte queued after restart is set carries new_message.
	task automatic push(input logic [7:0] b);
		raw_q.push_back('{b: b, nm: restart});
		restart = 1'b0;
	endtask

	task automatic push_text(input string s);
		for (int i = 0; i < s.len(); i++) begin
			push(s[i]);
		end
	endtask

	task automatic push_hex(input logic [31:0] v);
		int         n;
		logic [3:0] nib;
		n = 1;
		while (n < 8 && (v >> (4 * n)) != 0) begin
			n++;
		end
		repeat (($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0) begin
			push("0");
		end
		for (int i = n - 1; i >= 0; i--) begin
			nib = v[4 * i +: 4];
			if (nib < 10) begin
				push(8'h30 + nib);
			end else begin
				push(($urandom_range(0, 1) ? 8'h41 : 8'h61) + nib - 8'd10);
			end
		end
	endtask

	// Extension text: opens with a non-digit, may hold digits and bare LFs later.
	task automatic push_ext();
		logic [7:0] b;
		do begin
			b = 8'($urandom_range(0, 255));
		end while (b == CHAR_CR || is_hex(b));
		push(b);
		repeat ($urandom_range(0, 4)) begin
			b = 8'($urandom_range(0, 255));
			push((b == CHAR_CR) ? 8'h3B : b);
		end
	endtask

	task automatic flush();
		raw_t it;
		while (raw_q.size() > 0) begin
			it = raw_q.pop_front();
			while (!no_idle && $urandom_range(0, 99) < 21) begin
				s_tvalid <= 1'b0;
				@(negedge clk);
			end
			s_tvalid <= 1'b1;
			s_tdata <= it.b;
			s_tuser <= it.nm;
			do @(posedge clk); while (!s_tready);
			@(negedge clk);
			sent++;
		end
	endtask

	// Bytes without a result may still be in flight when the last word arrives.
	task automatic drain();
		s_tvalid <= 1'b0;
		while (pending != 0) begin
			@(negedge clk);
		end
		repeat (4) @(negedge clk);
	endtask

	task automatic set_limit(input logic [LEN_BITS-1:0] v);
		drain();
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
		limit = v;
		settings++;
	endtask

	task automatic random_phase(input int target);
		int          start;
		int          r;
		int          len;
		logic [31:0] v;
		logic [7:0]  b;
		start = sent;
		while (sent - start < target) begin
			r = $urandom_range(0, 99);
			messages++;
			restart = 1'b1;
			if (r < 68) begin
				repeat ($urandom_range(0, 3)) begin
					len = (limit == 0) ? 0 : $urandom_range(1, (limit < 12) ? limit : 12);
					if (len > 0) begin
						push_hex(len);
						if ($urandom_range(0, 3) == 0) begin
							push_ext();
						end
						push(CHAR_CR);
						push(CHAR_LF);
						repeat (len) push(8'($urandom_range(0, 255)));
						if ($urandom_range(0, 1)) begin
							push(CHAR_CR);
							push(CHAR_LF);
						end else begin
							push(8'($urandom_range(0, 255)));
							push(8'($urandom_range(0, 255)));
						end
					end
				end
				push_hex(0);
				if ($urandom_range(0, 3) == 0) begin
					push_ext();
				end
				push(CHAR_CR);
				push(CHAR_LF);
				push(8'($urandom_range(0, 255)));
				push(8'($urandom_range(0, 255)));
				if ($urandom_range(0, 9) == 0) begin
					repeat ($urandom_range(1, 2)) push(8'($urandom_range(0, 255)));
				end
			end else if (r < 76) begin
				// A chunk with a length up to the limit, which the next message may cut short.
				v = $urandom_range(0, 1) ? 32'(limit) : $urandom_range(0, 32'(limit));
				push_hex(v);
				push(CHAR_CR);
				push(CHAR_LF);
				repeat ($urandom_range(0, 5)) push(8'($urandom_range(0, 255)));
			end else if (r < 84) begin
				if (limit == MAX_LEN_RESET || $urandom_range(0, 1)) begin
					v = $urandom_range(32'h0100_0000, 32'hFFFF_FFFF);
				end else begin
					v = $urandom_range(32'(limit) + 1, 32'h00FF_FFFF);
				end
				push_hex(v);
				repeat ($urandom_range(0, 2)) push(8'($urandom_range(0, 255)));
			end else if (r < 92) begin
				if ($urandom_range(0, 1)) begin
					if ($urandom_range(0, 1)) begin
						push_ext();
					end
					push(CHAR_CR);
				end else begin
					push_hex($urandom_range(0, 32'(limit)));
					push(CHAR_CR);
					b = 8'($urandom_range(0, 255));
					push((b == CHAR_LF) ? CHAR_CR : b);
				end
			end else begin
				repeat ($urandom_range(1, 8)) begin
					restart = ($urandom_range(0, 7) == 0);
					push(8'($urandom_range(0, 255)));
				end
			end
			flush();
		end
	endtask

	initial begin : stimulus
		logic [LEN_BITS-1:0] limits [6];
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed part under the reset limit: the largest length with one data
		// byte, an overflowing length, a line with no digits, CR without LF, and
		// a terminal line carrying a bare LF, followed by a dropped byte.
		restart = 1'b1;
		push_text("FfFfFf\r\n");
		push(8'hFF);
		restart = 1'b1;
		push_text("1000000");
		restart = 1'b1;
		push(CHAR_CR);
		restart = 1'b1;
		push_text("a\rZ");
		restart = 1'b1;
		push_text("0\n\r\n");
		push(8'h00);
		push(8'hFF);
		push(8'h41);
		messages += 5;
		flush();

		limits[0] = MAX_LEN_RESET;
		limits[1] = '0;
		limits[2] = 24'd1;
		limits[3] = LEN_BITS'($urandom_range(16, 4095));
		limits[4] = LEN_BITS'($urandom_range(0, 32'h00FF_FFFF));
		limits[5] = MAX_LEN_RESET;
		for (int i = 0; i < 6; i++) begin
			set_limit(limits[i]);
			no_idle = (i == 3);
			random_phase(265);
		end
		no_idle = 1'b0;
		drain();

		$display("Sent %0d bytes in %0d messages under %0d length limits.",
			sent, messages, settings);
		$display("Checked %0d payload words, %0d end results and %0d format errors.",
			data_seen, end_seen, err_seen);
		if (fail_count == 0 && pending == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

`default_nettype wire
